>>> rtl/vpcm_pkg.sv
// Package for the vector program counter memory.
// Holds the command codes, stream widths and the control line item type.
// No dependencies.
package vpcm_pkg;

    typedef enum logic [1:0] {
        CMD_SIGNAL = 2'd0,
        CMD_RAM_WR = 2'd1,
        CMD_ROM_WR = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    localparam int PC_W        = 12;
    localparam int BYTE_W      = 8;
    localparam int MADDR_W     = 12;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic              counter_clock;
        logic              counter_load_n;
        logic              stack_write_n;
        logic              stack_read_n;
        logic              sp_clock;
        logic              sp_up_n;
        logic [PC_W-1:0]   load_address;
    } lines_t;

    typedef struct packed {
        logic cclk;
        logic load_n;
        logic swr_n;
        logic spclk;
    } prev_t;

endpackage

>>> rtl/vector_program_counter_memory.sv
// Top level of the vector program counter memory.
// Instantiates vpcm_ctrl and two vpcm_mem stores; depends on vpcm_pkg.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with the command in s_tuser and
//   the control lines, load address and write address/byte in s_tdata.
//   Every item yields exactly one result on m_tvalid/m_tready carrying the
//   memory byte at counter*2+address_low_bit, the counter and the stack
//   pointer as they stand after the item.
//   Pipeline: the accepting edge loads the read stage and the memory read; the
//   result register is loaded from the read stage once it is empty or being
//   taken, and it drives m_tvalid.
//   Throughput: one item per cycle unless m_tready stalls or the RAM clear
//   runs; the counter logic and memory read port each take one item per cycle.
//   Reset: counter, pointer, stack and line history clear at once; the RAM is
//   then swept to zero, one byte per cycle, over all RAM_BYTES bytes, while
//   s_tready stays low. The ROM is not cleared and must be written before read.
//   Stall: while m_tready is low the result holds; one more item can be
//   taken into the read stage, after which s_tready drops.
module vector_program_counter_memory
    import vpcm_pkg::*;
#(
    parameter int RAM_BYTES   = 2048,
    parameter int ROM_BYTES   = 4096,
    parameter int STACK_DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] counter_clock, [1] counter_load_n, [2] stack_write_n, [3] stack_read_n,
    // [4] sp_clock, [5] sp_up_n, [6] address_low_bit, [18:7] load_address,
    // [30:19] mem_address, [38:31] mem_data, [39] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] data, [19:8] counter, [21:20] stack_pointer, [23:22] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int RAM_AW = $clog2(RAM_BYTES);
    localparam int ROM_AW = $clog2(ROM_BYTES);

    function automatic logic [MADDR_W-1:0] fold(input logic [MADDR_W-1:0] v,
                                                 input int unsigned d);
        logic [MADDR_W-1:0] r;
        r = v;
        for (int k = 1; k <= 16; k++)
        begin
            if ({5'b0, v} >= 17'(k * d))
            begin
                r = v - MADDR_W'(k * d);
            end
        end
        return r;
    endfunction

    cmd_t                cmd;
    lines_t              lines;
    logic                low_bit;
    logic [MADDR_W-1:0]  mem_address;
    logic [BYTE_W-1:0]   mem_data;
    logic                accept;
    logic                advance;

    logic [PC_W-1:0]     pc_next;
    logic [1:0]          sp_next;
    logic [PC_W:0]       byte_addr;

    logic                clear_reg;
    logic                clear_next;
    logic [RAM_AW-1:0]   clr_addr_reg;
    logic [RAM_AW-1:0]   clr_addr_next;

    logic [MADDR_W-1:0]  ram_wfold;
    logic [MADDR_W-1:0]  rom_wfold;
    logic [MADDR_W-1:0]  ram_rfold;
    logic [MADDR_W-1:0]  rom_rfold;
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic                rom_we;
    logic [BYTE_W-1:0]   ram_rdata;
    logic [BYTE_W-1:0]   rom_rdata;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [PC_W-1:0]     s1_pc_reg;
    logic [1:0]          s1_sp_reg;
    logic                s1_rom_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic [BYTE_W-1:0]   rd_byte;

    always_comb
    begin
        cmd                  = cmd_t'(s_tuser);
        lines.counter_clock  = s_tdata[0];
        lines.counter_load_n = s_tdata[1];
        lines.stack_write_n  = s_tdata[2];
        lines.stack_read_n   = s_tdata[3];
        lines.sp_clock       = s_tdata[4];
        lines.sp_up_n        = s_tdata[5];
        low_bit              = s_tdata[6];
        lines.load_address   = s_tdata[18:7];
        mem_address          = s_tdata[30:19];
        mem_data             = s_tdata[38:31];
    end

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !clear_reg && (!s1_valid_reg || advance);
    assign accept   = s_tvalid && s_tready;

    vpcm_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept && (cmd == CMD_SIGNAL)),
        .lines   (lines),
        .pc_next (pc_next),
        .sp_next (sp_next)
    );

    assign byte_addr = {pc_next, low_bit};

    always_comb
    begin
        ram_wfold = fold(mem_address, RAM_BYTES);
        rom_wfold = fold(mem_address, ROM_BYTES);
        ram_rfold = fold(byte_addr[MADDR_W-1:0], RAM_BYTES);
        rom_rfold = fold(byte_addr[MADDR_W-1:0], ROM_BYTES);

        if (clear_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = accept && (cmd == CMD_RAM_WR);
            ram_waddr = ram_wfold[RAM_AW-1:0];
            ram_wdata = mem_data;
        end
        rom_we = accept && (cmd == CMD_ROM_WR);

        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == RAM_AW'(RAM_BYTES - 1))
            begin
                clear_next    = 1'b0;
                clr_addr_next = '0;
            end
        end
    end

    vpcm_mem #(
        .DEPTH (RAM_BYTES),
        .WIDTH (BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ram_rfold[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    vpcm_mem #(
        .DEPTH (ROM_BYTES),
        .WIDTH (BYTE_W)
    ) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .waddr (rom_wfold[ROM_AW-1:0]),
        .wdata (mem_data),
        .re    (accept),
        .raddr (rom_rfold[ROM_AW-1:0]),
        .rdata (rom_rdata)
    );

    always_comb
    begin
        rd_byte       = s1_rom_reg ? rom_rdata : ram_rdata;
        out_data_next = {2'b00, s1_sp_reg, s1_pc_reg, rd_byte};

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pc_reg  <= pc_next;
            s1_sp_reg  <= sp_next;
            s1_rom_reg <= byte_addr[PC_W];
        end
        if (advance && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !s_tready)
        else $error("item taken during RAM clear");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before read stage");

    a_stalled_stage_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("item taken while read stage is stalled");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("stalled read stage dropped its item");

endmodule

>>> rtl/vpcm_mem.sv
// Single-port-write, single-port-read synchronous byte memory.
// Read data is registered; a read of the entry being written returns the new byte.
// No dependencies.
module vpcm_mem #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= store_reg[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/vpcm_ctrl.sv
// Program counter, stack pointer and return stack with edge detection.
// Computes the counter and pointer after a signal item; depends on vpcm_pkg.
module vpcm_ctrl
    import vpcm_pkg::*;
#(
    parameter int STACK_DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  lines_t          lines,
    output logic [PC_W-1:0] pc_next,
    output logic [1:0]      sp_next
);

    localparam int SPW = $clog2(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);

    logic [PC_W-1:0] pc_reg;
    logic [SPW-1:0]  sp_reg;
    prev_t           prev_reg;
    logic [PC_W-1:0] stack_reg [STACK_DEPTH];

    prev_t           now;
    logic            fall_swr;
    logic            rise_sp;
    logic            rise_cclk;
    logic            rise_load;
    logic [SPW-1:0]  sp_step;
    logic [SPW-1:0]  sp_new;
    logic [PC_W-1:0] top;
    logic [PC_W-1:0] pc_inc;
    logic [PC_W-1:0] pc_new;
    logic [SPW+1:0]  sp_wide;

    always_comb
    begin
        now.cclk   = lines.counter_clock;
        now.load_n = lines.counter_load_n;
        now.swr_n  = lines.stack_write_n;
        now.spclk  = lines.sp_clock;

        fall_swr  = prev_reg.swr_n & ~now.swr_n;
        rise_sp   = ~prev_reg.spclk & now.spclk;
        rise_cclk = ~prev_reg.cclk & now.cclk;
        rise_load = ~prev_reg.load_n & now.load_n;

        if (lines.sp_up_n)
        begin
            sp_step = (sp_reg == '0) ? SP_LAST : sp_reg - 1'b1;
        end
        else
        begin
            sp_step = (sp_reg == SP_LAST) ? '0 : sp_reg + 1'b1;
        end
        sp_new = rise_sp ? sp_step : sp_reg;

        // forward the entry written by this item
        if (fall_swr && (sp_new == sp_reg))
        begin
            top = pc_reg;
        end
        else
        begin
            top = stack_reg[sp_new];
        end

        pc_inc = (rise_cclk && now.load_n) ? pc_reg + 1'b1 : pc_reg;
        if (!now.load_n || rise_load)
        begin
            pc_new = lines.stack_read_n ? lines.load_address : top;
        end
        else
        begin
            pc_new = pc_inc;
        end

        pc_next = step ? pc_new : pc_reg;
        sp_wide = {2'b00, (step ? sp_new : sp_reg)};
        sp_next = sp_wide[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            sp_reg   <= '0;
            prev_reg <= '0;
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stack_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            if (fall_swr)
            begin
                stack_reg[sp_reg] <= pc_reg;
            end
            pc_reg   <= pc_new;
            sp_reg   <= sp_new;
            prev_reg <= now;
        end
    end

endmodule
